/* rtl/assert_macros.svh */
// Assertion helpers for the RTL files; only e2cb_arc.sv includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define E2CB_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define E2CB_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/e2cb_pkg.sv */
`timescale 1ns / 1ps
package e2cb_pkg;

    localparam int COORD_W    = 32;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int ROOT_W     = 32;
    localparam int SQ_REM_W   = ROOT_W + 3;
    localparam int RAD_W      = 64;
    localparam int SQ_STAGES  = ROOT_W / 2;
    localparam int LEN_W      = ROOT_W + 1;
    localparam int QUO_W      = 32;
    localparam int DV_REM_W   = LEN_W + 1;
    localparam int NUM_W      = 64;
    localparam int DV_STAGES  = QUO_W / 2;
    localparam int UNIT_SHIFT = 29;
    localparam int KAPPA_W    = 29;
    localparam logic [KAPPA_W-1:0] KAPPA_Q29 = 29'd296505617;
    localparam int KA_W       = 34;
    localparam int R_W        = 35;
    localparam int B_W        = 36;
    localparam int CRD_W      = 40;
    localparam int S_DATA_W   = 192;
    localparam int M_DATA_W   = 264;

    typedef struct packed {
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [DIFF_W-1:0]  dx;
        logic signed [DIFF_W-1:0]  dy;
        logic signed [DIFF_W-1:0]  qx;
        logic signed [DIFF_W-1:0]  qy;
        logic signed [KA_W-1:0]    kax;
        logic signed [KA_W-1:0]    kay;
        logic                      wide;
        logic                      degen;
    } side_t;

    typedef struct packed {
        logic [SQ_REM_W-1:0] rem;
        logic [ROOT_W-1:0]   root;
    } sq_t;

    typedef struct packed {
        sq_t              acc;
        logic [RAD_W-1:0] rad;
        side_t            side;
    } sq_stage_t;

    typedef struct packed {
        logic [DV_REM_W-1:0] rem;
        logic [QUO_W-1:0]    q;
    } dv_t;

    typedef struct packed {
        dv_t              x;
        dv_t              y;
        logic [QUO_W-1:0] nx;
        logic [QUO_W-1:0] ny;
        logic [LEN_W-1:0] d;
        side_t            side;
    } dv_stage_t;

    typedef struct packed {
        logic [3:0][CRD_W-1:0] px;
        logic [3:0][CRD_W-1:0] py;
        logic [3:0][CRD_W-1:0] tx;
        logic [3:0][CRD_W-1:0] ty;
        logic                  degen;
    } arc_t;

    function automatic sq_t sqrt_step(input sq_t cur, input logic [1:0] pair);
        sq_t                 res;
        logic [SQ_REM_W-1:0] part;
        logic [SQ_REM_W-1:0] trial;
        part  = {cur.rem[SQ_REM_W-3:0], pair};
        trial = {1'b0, cur.root, 2'b01};
        if (part >= trial) begin
            res.rem  = part - trial;
            res.root = {cur.root[ROOT_W-2:0], 1'b1};
        end else begin
            res.rem  = part;
            res.root = {cur.root[ROOT_W-2:0], 1'b0};
        end
        return res;
    endfunction

    function automatic dv_t div_step(input dv_t cur, input logic nbit,
                                     input logic [LEN_W-1:0] d);
        dv_t                 res;
        logic [DV_REM_W-1:0] part;
        logic [DV_REM_W-1:0] dd;
        part = {cur.rem[DV_REM_W-2:0], nbit};
        dd   = {1'b0, d};
        if (part >= dd) begin
            res.rem = part - dd;
            res.q   = {cur.q[QUO_W-2:0], 1'b1};
        end else begin
            res.rem = part;
            res.q   = {cur.q[QUO_W-2:0], 1'b0};
        end
        return res;
    endfunction

    function automatic logic [COORD_W-1:0] sat32(input logic signed [CRD_W-1:0] a);
        logic [COORD_W-1:0] res;
        if (!a[CRD_W-1] && (|a[CRD_W-2:COORD_W-1])) begin
            res = {1'b0, {(COORD_W-1){1'b1}}};
        end else if (a[CRD_W-1] && !(&a[CRD_W-2:COORD_W-1])) begin
            res = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            res = a[COORD_W-1:0];
        end
        return res;
    endfunction

endpackage

/* rtl/e2cb_sqrt.sv */
`timescale 1ns / 1ps
module e2cb_sqrt (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [e2cb_pkg::RAD_W-1:0]   rad,
    input  e2cb_pkg::side_t              side_in,
    output logic                         out_valid,
    output logic [e2cb_pkg::ROOT_W-1:0]  root,
    output e2cb_pkg::side_t              side_out
);
    import e2cb_pkg::*;

    sq_stage_t             stg_reg  [SQ_STAGES];
    sq_stage_t             stg_cur  [SQ_STAGES];
    sq_stage_t             stg_next [SQ_STAGES];
    logic [SQ_STAGES-1:0]  vld_reg;

    always_comb begin
        stg_cur[0].acc  = '0;
        stg_cur[0].rad  = rad;
        stg_cur[0].side = side_in;
        for (int k = 1; k < SQ_STAGES; k++) begin
            stg_cur[k] = stg_reg[k-1];
        end
        for (int k = 0; k < SQ_STAGES; k++) begin
            stg_next[k].acc  = sqrt_step(sqrt_step(stg_cur[k].acc,
                                                   stg_cur[k].rad[RAD_W-1 -: 2]),
                                         stg_cur[k].rad[RAD_W-3 -: 2]);
            stg_next[k].rad  = stg_cur[k].rad << 4;
            stg_next[k].side = stg_cur[k].side;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[SQ_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < SQ_STAGES; k++) begin
                stg_reg[k] <= stg_next[k];
            end
        end
    end

    assign out_valid = vld_reg[SQ_STAGES-1];
    assign root      = stg_reg[SQ_STAGES-1].acc.root;
    assign side_out  = stg_reg[SQ_STAGES-1].side;

endmodule

/* rtl/e2cb_div.sv */
`timescale 1ns / 1ps
module e2cb_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [e2cb_pkg::LEN_W-1:0]  d,
    input  logic [e2cb_pkg::NUM_W-1:0]  nx,
    input  logic [e2cb_pkg::NUM_W-1:0]  ny,
    input  e2cb_pkg::side_t             side_in,
    output logic                        out_valid,
    output logic [e2cb_pkg::QUO_W-1:0]  qx,
    output logic [e2cb_pkg::QUO_W-1:0]  qy,
    output e2cb_pkg::side_t             side_out
);
    import e2cb_pkg::*;

    dv_stage_t             stg_reg  [DV_STAGES];
    dv_stage_t             stg_cur  [DV_STAGES];
    dv_stage_t             stg_next [DV_STAGES];
    logic [DV_STAGES-1:0]  vld_reg;

    always_comb begin
        stg_cur[0].x.rem = DV_REM_W'(nx[NUM_W-1 -: QUO_W]);
        stg_cur[0].x.q   = '0;
        stg_cur[0].y.rem = DV_REM_W'(ny[NUM_W-1 -: QUO_W]);
        stg_cur[0].y.q   = '0;
        stg_cur[0].nx    = nx[QUO_W-1:0];
        stg_cur[0].ny    = ny[QUO_W-1:0];
        stg_cur[0].d     = d;
        stg_cur[0].side  = side_in;
        for (int k = 1; k < DV_STAGES; k++) begin
            stg_cur[k] = stg_reg[k-1];
        end
        for (int k = 0; k < DV_STAGES; k++) begin
            stg_next[k].x    = div_step(div_step(stg_cur[k].x, stg_cur[k].nx[QUO_W-1],
                                                 stg_cur[k].d),
                                        stg_cur[k].nx[QUO_W-2], stg_cur[k].d);
            stg_next[k].y    = div_step(div_step(stg_cur[k].y, stg_cur[k].ny[QUO_W-1],
                                                 stg_cur[k].d),
                                        stg_cur[k].ny[QUO_W-2], stg_cur[k].d);
            stg_next[k].nx   = stg_cur[k].nx << 2;
            stg_next[k].ny   = stg_cur[k].ny << 2;
            stg_next[k].d    = stg_cur[k].d;
            stg_next[k].side = stg_cur[k].side;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[DV_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < DV_STAGES; k++) begin
                stg_reg[k] <= stg_next[k];
            end
        end
    end

    assign out_valid = vld_reg[DV_STAGES-1];
    assign qx        = stg_reg[DV_STAGES-1].x.q;
    assign qy        = stg_reg[DV_STAGES-1].y.q;
    assign side_out  = stg_reg[DV_STAGES-1].side;

endmodule

/* rtl/e2cb_arc.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
module e2cb_arc (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  e2cb_pkg::arc_t                 arc,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // segment_index, start_x, start_y, end_x, end_y, ctrl_one_x, ctrl_one_y,
    // ctrl_two_x, ctrl_two_y, zero fill
    output logic [e2cb_pkg::M_DATA_W-1:0]  m_axis_tdata,
    // degenerate
    output logic                           m_axis_tuser,
    output logic                           m_axis_tlast
);
    import e2cb_pkg::*;

    arc_t        arc_reg;
    logic        hold_valid_reg;
    logic        hold_valid_next;
    logic [1:0]  idx_reg;
    logic [1:0]  idx_next;
    logic [1:0]  nidx;
    logic        last_beat;
    logic        beat_take;
    logic        load;
    logic signed [CRD_W-1:0] pi_x, pi_y, pn_x, pn_y, ti_x, ti_y, tn_x, tn_y;
    logic signed [CRD_W-1:0] c1_x, c1_y, c2_x, c2_y;

    assign last_beat = arc_reg.degen || (idx_reg == 2'd3);
    assign beat_take = hold_valid_reg && m_axis_tready;
    assign in_ready  = !hold_valid_reg || (m_axis_tready && last_beat);
    assign load      = in_valid && in_ready;

    always_comb begin
        hold_valid_next = hold_valid_reg;
        idx_next        = idx_reg;
        if (load) begin
            hold_valid_next = 1'b1;
            idx_next        = '0;
        end else if (beat_take) begin
            if (last_beat) begin
                hold_valid_next = 1'b0;
            end else begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
            idx_reg        <= '0;
        end else begin
            hold_valid_reg <= hold_valid_next;
            idx_reg        <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            arc_reg <= arc;
        end
    end

    assign nidx = idx_reg + 2'd1;
    assign pi_x = arc_reg.px[idx_reg];
    assign pi_y = arc_reg.py[idx_reg];
    assign pn_x = arc_reg.px[nidx];
    assign pn_y = arc_reg.py[nidx];
    assign ti_x = arc_reg.tx[idx_reg];
    assign ti_y = arc_reg.ty[idx_reg];
    assign tn_x = arc_reg.tx[nidx];
    assign tn_y = arc_reg.ty[nidx];
    assign c1_x = pi_x + ti_x;
    assign c1_y = pi_y + ti_y;
    assign c2_x = pn_x - tn_x;
    assign c2_y = pn_y - tn_y;

    always_comb begin
        if (arc_reg.degen) begin
            m_axis_tdata = '0;
        end else begin
            m_axis_tdata = {6'd0, sat32(c2_y), sat32(c2_x), sat32(c1_y), sat32(c1_x),
                            sat32(pn_y), sat32(pn_x), sat32(pi_y), sat32(pi_x), idx_reg};
        end
    end

    assign m_axis_tvalid = hold_valid_reg;
    assign m_axis_tuser  = arc_reg.degen;
    assign m_axis_tlast  = last_beat;

    `E2CB_ASSERT_NXT(a_idx_step, aclk, aresetn, beat_take && !last_beat, hold_valid_reg && (idx_reg == $past(idx_reg) + 2'd1), "segment did not advance")
    `E2CB_ASSERT_NXT(a_drain, aclk, aresetn, beat_take && last_beat && !load, !hold_valid_reg, "held item not released")
    `E2CB_ASSERT_IMP(a_degen_idx, aclk, aresetn, hold_valid_reg && arc_reg.degen, idx_reg == 2'd0, "degenerate beat off segment zero")

endmodule

/* rtl/ellipse_to_cubic_bezier_top.sv */
`timescale 1ns / 1ps
// Throughput: 4 result beats per input, one when its major length is zero; the arc stage
// takes each input with the last beat of the one before, so such inputs go one every
// cycle; the result port sets the rate.
// A 16-stage square root and a 16-stage dual divider carry most of the latency.
// Reset: synchronous, active low; clears every valid bit and the segment counter.
module ellipse_to_cubic_bezier_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // center_x, center_y, axis_end_x, axis_end_y, cursor_x, cursor_y
    input  logic [e2cb_pkg::S_DATA_W-1:0]  s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // segment_index, start_x, start_y, end_x, end_y, ctrl_one_x, ctrl_one_y,
    // ctrl_two_x, ctrl_two_y, zero fill
    output logic [e2cb_pkg::M_DATA_W-1:0]  m_axis_tdata,
    // degenerate
    output logic                           m_axis_tuser,
    output logic                           m_axis_tlast
);
    import e2cb_pkg::*;

    localparam logic [NUM_W+1:0] HALF_W = (NUM_W+2)'(1) << (UNIT_SHIFT - 1);

    logic en;
    logic ser_ready;

    // Front: differences, squares, kappa times the major vector.
    logic signed [COORD_W-1:0] in_cx, in_cy, in_ax, in_ay, in_qx, in_qy;
    side_t f1_side_reg, f1_side_next;
    logic  f1_valid_reg;

    assign in_cx = s_axis_tdata[31:0];
    assign in_cy = s_axis_tdata[63:32];
    assign in_ax = s_axis_tdata[95:64];
    assign in_ay = s_axis_tdata[127:96];
    assign in_qx = s_axis_tdata[159:128];
    assign in_qy = s_axis_tdata[191:160];

    always_comb begin
        f1_side_next       = '0;
        f1_side_next.cx    = in_cx;
        f1_side_next.cy    = in_cy;
        f1_side_next.dx    = {in_ax[COORD_W-1], in_ax} - {in_cx[COORD_W-1], in_cx};
        f1_side_next.dy    = {in_ay[COORD_W-1], in_ay} - {in_cy[COORD_W-1], in_cy};
        f1_side_next.qx    = {in_qx[COORD_W-1], in_qx} - {in_cx[COORD_W-1], in_cx};
        f1_side_next.qy    = {in_qy[COORD_W-1], in_qy} - {in_cy[COORD_W-1], in_cy};
    end

    logic [DIFF_W-1:0]         f2_mx, f2_my;
    logic [COORD_W-2:0]        f2_hx, f2_hy;
    side_t                     f2_side_reg, f2_side_next;
    logic [2*COORD_W-3:0]      f2_sqx_reg, f2_sqy_reg;
    logic [DIFF_W+KAPPA_W-1:0] f2_kamx_reg, f2_kamy_reg;
    logic                      f2_valid_reg;

    assign f2_mx = f1_side_reg.dx[DIFF_W-1] ? DIFF_W'(-f1_side_reg.dx) : f1_side_reg.dx;
    assign f2_my = f1_side_reg.dy[DIFF_W-1] ? DIFF_W'(-f1_side_reg.dy) : f1_side_reg.dy;

    always_comb begin
        f2_side_next      = f1_side_reg;
        f2_side_next.wide = f2_mx[DIFF_W-1] | f2_mx[DIFF_W-2] |
                            f2_my[DIFF_W-1] | f2_my[DIFF_W-2];
    end

    assign f2_hx = f2_side_next.wide ? f2_mx[DIFF_W-2:1] : f2_mx[DIFF_W-3:0];
    assign f2_hy = f2_side_next.wide ? f2_my[DIFF_W-2:1] : f2_my[DIFF_W-3:0];

    side_t                     f3_side_reg, f3_side_next;
    logic [RAD_W-1:0]          f3_rad_reg;
    logic                      f3_valid_reg;
    logic [DIFF_W+KAPPA_W-1:0] f3_kx, f3_ky;

    assign f3_kx = f2_kamx_reg + (DIFF_W+KAPPA_W)'(HALF_W);
    assign f3_ky = f2_kamy_reg + (DIFF_W+KAPPA_W)'(HALF_W);

    always_comb begin
        f3_side_next     = f2_side_reg;
        f3_side_next.kax = f2_side_reg.dx[DIFF_W-1] ?
                           KA_W'(-{1'b0, f3_kx[DIFF_W+KAPPA_W-1:UNIT_SHIFT]}) :
                           {1'b0, f3_kx[DIFF_W+KAPPA_W-1:UNIT_SHIFT]};
        f3_side_next.kay = f2_side_reg.dy[DIFF_W-1] ?
                           KA_W'(-{1'b0, f3_ky[DIFF_W+KAPPA_W-1:UNIT_SHIFT]}) :
                           {1'b0, f3_ky[DIFF_W+KAPPA_W-1:UNIT_SHIFT]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
            f3_valid_reg <= 1'b0;
        end else if (en) begin
            f1_valid_reg <= s_axis_tvalid;
            f2_valid_reg <= f1_valid_reg;
            f3_valid_reg <= f2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f1_side_reg <= f1_side_next;
            f2_side_reg <= f2_side_next;
            f2_sqx_reg  <= f2_hx * f2_hx;
            f2_sqy_reg  <= f2_hy * f2_hy;
            f2_kamx_reg <= f2_mx * KAPPA_Q29;
            f2_kamy_reg <= f2_my * KAPPA_Q29;
            f3_side_reg <= f3_side_next;
            f3_rad_reg  <= RAD_W'(f2_sqx_reg) + RAD_W'(f2_sqy_reg);
        end
    end

    // Major length.
    logic              sq_valid;
    logic [ROOT_W-1:0] sq_root;
    side_t             sq_side;

    e2cb_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (f3_valid_reg),
        .rad       (f3_rad_reg),
        .side_in   (f3_side_reg),
        .out_valid (sq_valid),
        .root      (sq_root),
        .side_out  (sq_side)
    );

    logic [LEN_W-1:0]  l_len;
    logic [DIFF_W-1:0] l_mdx, l_mdy;
    side_t             l_side_reg, l_side_next;
    logic [LEN_W-1:0]  l_len_reg;
    logic [NUM_W-1:0]  l_nx_reg, l_ny_reg;
    logic              l_valid_reg;

    assign l_len = sq_side.wide ? {sq_root, 1'b0} : {1'b0, sq_root};
    assign l_mdx = sq_side.dx[DIFF_W-1] ? DIFF_W'(-sq_side.dx) : sq_side.dx;
    assign l_mdy = sq_side.dy[DIFF_W-1] ? DIFF_W'(-sq_side.dy) : sq_side.dy;

    always_comb begin
        l_side_next       = sq_side;
        l_side_next.degen = (sq_root == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            l_valid_reg <= 1'b0;
        end else if (en) begin
            l_valid_reg <= sq_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            l_side_reg <= l_side_next;
            l_len_reg  <= l_len;
            l_nx_reg   <= {2'b00, l_mdx, {UNIT_SHIFT{1'b0}}} + NUM_W'(l_len[LEN_W-1:1]);
            l_ny_reg   <= {2'b00, l_mdy, {UNIT_SHIFT{1'b0}}} + NUM_W'(l_len[LEN_W-1:1]);
        end
    end

    // Unit axis.
    logic             dv_valid;
    logic [QUO_W-1:0] dv_qx, dv_qy;
    side_t            dv_side;

    e2cb_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (l_valid_reg),
        .d         (l_len_reg),
        .nx        (l_nx_reg),
        .ny        (l_ny_reg),
        .side_in   (l_side_reg),
        .out_valid (dv_valid),
        .qx        (dv_qx),
        .qy        (dv_qy),
        .side_out  (dv_side)
    );

    // Back: minor radius, minor vector, kappa times the minor vector.
    side_t                         p1_side_reg, p2_side_reg, p3_side_reg;
    side_t                         p4_side_reg, p5_side_reg, p6_side_reg;
    logic [5:0]                    pv_reg;
    logic signed [QUO_W-1:0]       p1_ux_reg, p1_uy_reg, p2_ux_reg, p2_uy_reg;
    logic signed [QUO_W-1:0]       p3_ux_reg, p3_uy_reg;
    logic signed [QUO_W-1:0]       p2_vx;
    logic signed [DIFF_W+QUO_W-1:0] p2_pa_reg, p2_pb_reg;
    logic signed [DIFF_W+QUO_W:0]  p3_dot;
    logic [DIFF_W+QUO_W:0]         p3_dm, p3_rs;
    logic [R_W-1:0]                p3_r_reg;
    logic [QUO_W-2:0]              p4_mvx, p4_mvy;
    logic [R_W+QUO_W-2:0]          p4_pbx_reg, p4_pby_reg;
    logic                          p4_nbx_reg, p4_nby_reg;
    logic [R_W+QUO_W-2:0]          p5_rbx, p5_rby;
    logic signed [B_W-1:0]         p5_bx_reg, p5_by_reg, p6_bx_reg, p6_by_reg;
    logic [B_W-2:0]                p6_mbx, p6_mby;
    logic [B_W+KAPPA_W-2:0]        p6_kbx_reg, p6_kby_reg;

    assign p2_vx  = -p1_uy_reg;
    assign p3_dot = {p2_pa_reg[DIFF_W+QUO_W-1], p2_pa_reg} +
                    {p2_pb_reg[DIFF_W+QUO_W-1], p2_pb_reg};
    assign p3_dm  = p3_dot[DIFF_W+QUO_W] ? (DIFF_W+QUO_W+1)'(-p3_dot) : p3_dot;
    assign p3_rs  = p3_dm + (DIFF_W+QUO_W+1)'(HALF_W);
    assign p4_mvx = p3_uy_reg[QUO_W-1] ? (QUO_W-1)'(-p3_uy_reg) : p3_uy_reg[QUO_W-2:0];
    assign p4_mvy = p3_ux_reg[QUO_W-1] ? (QUO_W-1)'(-p3_ux_reg) : p3_ux_reg[QUO_W-2:0];
    assign p5_rbx = p4_pbx_reg + (R_W+QUO_W-1)'(HALF_W);
    assign p5_rby = p4_pby_reg + (R_W+QUO_W-1)'(HALF_W);
    assign p6_mbx = p5_bx_reg[B_W-1] ? (B_W-1)'(-p5_bx_reg) : p5_bx_reg[B_W-2:0];
    assign p6_mby = p5_by_reg[B_W-1] ? (B_W-1)'(-p5_by_reg) : p5_by_reg[B_W-2:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pv_reg <= '0;
        end else if (en) begin
            pv_reg <= {pv_reg[4:0], dv_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_side_reg <= dv_side;
            p1_ux_reg   <= dv_side.dx[DIFF_W-1] ? (QUO_W'(0) - dv_qx) : dv_qx;
            p1_uy_reg   <= dv_side.dy[DIFF_W-1] ? (QUO_W'(0) - dv_qy) : dv_qy;
            p2_side_reg <= p1_side_reg;
            p2_ux_reg   <= p1_ux_reg;
            p2_uy_reg   <= p1_uy_reg;
            p2_pa_reg   <= p1_side_reg.qx * p2_vx;
            p2_pb_reg   <= p1_side_reg.qy * p1_ux_reg;
            p3_side_reg <= p2_side_reg;
            p3_ux_reg   <= p2_ux_reg;
            p3_uy_reg   <= p2_uy_reg;
            p3_r_reg    <= p3_rs[R_W+UNIT_SHIFT-1:UNIT_SHIFT];
            p4_side_reg <= p3_side_reg;
            p4_pbx_reg  <= p3_r_reg * p4_mvx;
            p4_pby_reg  <= p3_r_reg * p4_mvy;
            p4_nbx_reg  <= !p3_uy_reg[QUO_W-1];
            p4_nby_reg  <= p3_ux_reg[QUO_W-1];
            p5_side_reg <= p4_side_reg;
            p5_bx_reg   <= p4_nbx_reg ?
                           B_W'(-{1'b0, p5_rbx[R_W+UNIT_SHIFT-1:UNIT_SHIFT]}) :
                           {1'b0, p5_rbx[R_W+UNIT_SHIFT-1:UNIT_SHIFT]};
            p5_by_reg   <= p4_nby_reg ?
                           B_W'(-{1'b0, p5_rby[R_W+UNIT_SHIFT-1:UNIT_SHIFT]}) :
                           {1'b0, p5_rby[R_W+UNIT_SHIFT-1:UNIT_SHIFT]};
            p6_side_reg <= p5_side_reg;
            p6_bx_reg   <= p5_bx_reg;
            p6_by_reg   <= p5_by_reg;
            p6_kbx_reg  <= p6_mbx * KAPPA_Q29;
            p6_kby_reg  <= p6_mby * KAPPA_Q29;
        end
    end

    // Arc end points and tangents.
    logic [B_W+KAPPA_W-2:0]  a_rkx, a_rky;
    logic signed [B_W-1:0]   a_kbx, a_kby;
    logic signed [CRD_W-1:0] e_cx, e_cy, e_dx, e_dy, e_bx, e_by;
    logic signed [CRD_W-1:0] e_kax, e_kay, e_kbx, e_kby;
    arc_t                    a_arc;

    assign a_rkx = p6_kbx_reg + (B_W+KAPPA_W-1)'(HALF_W);
    assign a_rky = p6_kby_reg + (B_W+KAPPA_W-1)'(HALF_W);
    assign a_kbx = p6_bx_reg[B_W-1] ?
                   B_W'(-{1'b0, a_rkx[R_W+UNIT_SHIFT-1:UNIT_SHIFT]}) :
                   {1'b0, a_rkx[R_W+UNIT_SHIFT-1:UNIT_SHIFT]};
    assign a_kby = p6_by_reg[B_W-1] ?
                   B_W'(-{1'b0, a_rky[R_W+UNIT_SHIFT-1:UNIT_SHIFT]}) :
                   {1'b0, a_rky[R_W+UNIT_SHIFT-1:UNIT_SHIFT]};

    assign e_cx  = p6_side_reg.cx;
    assign e_cy  = p6_side_reg.cy;
    assign e_dx  = p6_side_reg.dx;
    assign e_dy  = p6_side_reg.dy;
    assign e_bx  = p6_bx_reg;
    assign e_by  = p6_by_reg;
    assign e_kax = p6_side_reg.kax;
    assign e_kay = p6_side_reg.kay;
    assign e_kbx = a_kbx;
    assign e_kby = a_kby;

    always_comb begin
        a_arc.px[0] = e_cx + e_dx;
        a_arc.py[0] = e_cy + e_dy;
        a_arc.px[1] = e_cx + e_bx;
        a_arc.py[1] = e_cy + e_by;
        a_arc.px[2] = e_cx - e_dx;
        a_arc.py[2] = e_cy - e_dy;
        a_arc.px[3] = e_cx - e_bx;
        a_arc.py[3] = e_cy - e_by;
        a_arc.tx[0] = e_kbx;
        a_arc.ty[0] = e_kby;
        a_arc.tx[1] = -e_kax;
        a_arc.ty[1] = -e_kay;
        a_arc.tx[2] = -e_kbx;
        a_arc.ty[2] = -e_kby;
        a_arc.tx[3] = e_kax;
        a_arc.ty[3] = e_kay;
        a_arc.degen = p6_side_reg.degen;
    end

    assign en            = !pv_reg[5] || ser_ready;
    assign s_axis_tready = en;

    e2cb_arc u_arc (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (pv_reg[5]),
        .in_ready      (ser_ready),
        .arc           (a_arc),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
